// ----- sv/ptcs_pkg.sv -----
// shared types, constants and helpers for the phase to clock block
package ptcs_pkg;

    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int TICK_BITS           = 7;
    localparam int PRIOR_TICK_BITS     = 8;
    localparam int OFFSET_W            = 15;
    localparam int SWING_W             = 13;
    localparam int RATIO_W             = 3;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = 15;

    localparam logic [PRIOR_TICK_BITS-1:0] PRIOR_TICK_NONE = 8'hFF;
    localparam logic [RATIO_W-1:0]         RATIO_RESET     = 3'd2;
    localparam logic [RATIO_W-1:0]         RATIO_MAX       = 3'd4;
    localparam logic [TICK_BITS-1:0]       TICK_ALL        = 7'h7F;
    localparam logic [TICK_BITS-1:0]       TICK_PAIR_MASK  = 7'h7E;
    localparam int                         SWING_TICK_BIT  = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_STOP = 2'd0,
        CFG_OFFSET     = 2'd1,
        CFG_SWING      = 2'd2,
        CFG_RATIO      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                       start_stop_enable;
        logic signed [OFFSET_W-1:0] offset_amount;
        logic [SWING_W-1:0]         swing_amount;
        logic [RATIO_W-1:0]         clock_ratio;
    } cfg_t;

    typedef struct packed {
        logic partner_playing;
        logic partner_sync_on;
        logic resync_request;
    } flags_t;

    // clock is high on the first two ticks of each period of 128 >> code ticks
    function automatic logic clock_high(input logic [TICK_BITS-1:0] tick,
                                        input logic [RATIO_W-1:0]   ratio);
        logic [RATIO_W-1:0]   code;
        logic [TICK_BITS-1:0] mask;
        code = (ratio > RATIO_MAX) ? RATIO_MAX : ratio;
        mask = (TICK_ALL >> code) & TICK_PAIR_MASK;
        return (tick & mask) == '0;
    endfunction

endpackage

// ----- sv/phase_to_clock_with_swing.sv -----
// a request passes through the input register, then the result register; out_stall can hold it in between
// throughput: one request per cycle while out_stall is low, set by the input and result registers
// the input register takes a new request while a result waits behind out_stall only if it is empty.
// reset (rst_n low, asynchronous) empties both stages, clears sync and levels,
// marks no prior tick and loads registers with ratio code 2, others zero
module phase_to_clock_with_swing #(
    parameter int PHASE_FRAC_BITS = ptcs_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ptcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ptcs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [PHASE_FRAC_BITS+1:0]          bar_phase,
    input  logic                                partner_playing,
    input  logic                                partner_sync_on,
    input  logic                                resync_request,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                clock_pulse,
    output logic                                bar_reset_pulse,
    output logic                                waiting_for_sync
);

    localparam int PHASE_W = PHASE_FRAC_BITS + 2;

    ptcs_pkg::cfg_t                     cfg_reg;
    ptcs_pkg::flags_t                   in_flags;
    ptcs_pkg::flags_t                   hold_flags;
    logic                               hold_valid;
    logic [PHASE_W-1:0]                 hold_phase;
    logic                               advance;
    logic [ptcs_pkg::TICK_BITS-1:0]     tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_stop_enable <= 1'b0;
            cfg_reg.offset_amount     <= '0;
            cfg_reg.swing_amount      <= '0;
            cfg_reg.clock_ratio       <= ptcs_pkg::RATIO_RESET;
        end
        else if (cfg_write)
        begin
            unique case (ptcs_pkg::cfg_reg_t'(cfg_index))
                ptcs_pkg::CFG_START_STOP:
                    cfg_reg.start_stop_enable <= cfg_data[0];
                ptcs_pkg::CFG_OFFSET:
                    cfg_reg.offset_amount <= cfg_data[ptcs_pkg::OFFSET_W-1:0];
                ptcs_pkg::CFG_SWING:
                    cfg_reg.swing_amount <= cfg_data[ptcs_pkg::SWING_W-1:0];
                ptcs_pkg::CFG_RATIO:
                    cfg_reg.clock_ratio <= cfg_data[ptcs_pkg::RATIO_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_flags.partner_playing = partner_playing;
    assign in_flags.partner_sync_on = partner_sync_on;
    assign in_flags.resync_request  = resync_request;

    ptcs_input_stage #(
        .PHASE_W (PHASE_W)
    ) u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .bar_phase  (bar_phase),
        .flags      (in_flags),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_phase (hold_phase),
        .hold_flags (hold_flags)
    );

    ptcs_tick_quant #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_quant (
        .phase         (hold_phase),
        .offset_amount (cfg_reg.offset_amount),
        .swing_amount  (cfg_reg.swing_amount),
        .tick          (tick)
    );

    ptcs_sync_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .hold_valid       (hold_valid),
        .hold_flags       (hold_flags),
        .tick             (tick),
        .cfg              (cfg_reg),
        .advance          (advance),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .clock_pulse      (clock_pulse),
        .bar_reset_pulse  (bar_reset_pulse),
        .waiting_for_sync (waiting_for_sync)
    );

endmodule

// ----- sv/ptcs_input_stage.sv -----
// input register stage with valid/stall handshake
module ptcs_input_stage #(
    parameter int PHASE_W = ptcs_pkg::PHASE_FRAC_BITS_DEF + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PHASE_W-1:0]   bar_phase,
    input  ptcs_pkg::flags_t     flags,
    input  logic                 advance,
    output logic                 hold_valid,
    output logic [PHASE_W-1:0]   hold_phase,
    output ptcs_pkg::flags_t     hold_flags
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [PHASE_W-1:0]   phase_reg;
    ptcs_pkg::flags_t     flags_reg;
    logic                 take;

    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            phase_reg <= bar_phase;
            flags_reg <= flags;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_phase = phase_reg;
    assign hold_flags = flags_reg;

endmodule

// ----- sv/ptcs_tick_quant.sv -----
// phase plus offset to tick, with swing requantize on odd sixteenths
module ptcs_tick_quant #(
    parameter int PHASE_FRAC_BITS = ptcs_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic [PHASE_FRAC_BITS+1:0]                 phase,
    input  logic signed [ptcs_pkg::OFFSET_W-1:0]       offset_amount,
    input  logic [ptcs_pkg::SWING_W-1:0]               swing_amount,
    output logic [ptcs_pkg::TICK_BITS-1:0]             tick
);

    localparam int W  = PHASE_FRAC_BITS + 2;
    localparam int EW = (W > ptcs_pkg::OFFSET_W) ? W : ptcs_pkg::OFFSET_W;
    localparam int LO = W - ptcs_pkg::TICK_BITS;

    logic [EW-1:0]                      offset_ext;
    logic [EW-1:0]                      sum;
    logic [EW-1:0]                      swung;
    logic [ptcs_pkg::TICK_BITS-1:0]     tick_plain;
    logic [ptcs_pkg::TICK_BITS-1:0]     tick_swung;

    // the tick wraps per bar, so only the low bar bits of the sum matter
    assign offset_ext = EW'(offset_amount);
    assign sum        = EW'(phase) + offset_ext;
    assign swung      = sum - EW'(swing_amount);
    assign tick_plain = sum[W-1:LO];
    assign tick_swung = swung[W-1:LO];
    assign tick       = tick_plain[ptcs_pkg::SWING_TICK_BIT] ? tick_swung : tick_plain;

endmodule

// ----- sv/ptcs_sync_core.sv -----
// sync tracking, held levels and the result register
module ptcs_sync_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            hold_valid,
    input  ptcs_pkg::flags_t                hold_flags,
    input  logic [ptcs_pkg::TICK_BITS-1:0]  tick,
    input  ptcs_pkg::cfg_t                  cfg,
    output logic                            advance,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            clock_pulse,
    output logic                            bar_reset_pulse,
    output logic                            waiting_for_sync
);

    logic                                   out_valid_reg;
    logic                                   synced_reg;
    logic                                   synced_next;
    logic                                   prior_playing_reg;
    logic                                   prior_playing_next;
    logic [ptcs_pkg::PRIOR_TICK_BITS-1:0]   prior_tick_reg;
    logic [ptcs_pkg::PRIOR_TICK_BITS-1:0]   prior_tick_next;
    logic                                   clock_level_reg;
    logic                                   clock_level_next;
    logic                                   reset_level_reg;
    logic                                   reset_level_next;
    logic                                   playing;
    logic                                   synced_mid;
    logic                                   update;

    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        synced_mid         = synced_reg && !hold_flags.resync_request;
        playing            = 1'b1;
        prior_playing_next = prior_playing_reg;
        if (hold_flags.partner_sync_on)
        begin
            if (cfg.start_stop_enable)
            begin
                playing = hold_flags.partner_playing;
                // play start drops sync
                if (playing && !prior_playing_reg)
                begin
                    synced_mid = 1'b0;
                end
            end
            prior_playing_next = playing;
        end

        update           = ({1'b0, tick} != prior_tick_reg) || !synced_mid;
        synced_next      = synced_mid;
        clock_level_next = clock_level_reg;
        reset_level_next = reset_level_reg;
        prior_tick_next  = prior_tick_reg;
        if (update)
        begin
            if (tick == '0)
            begin
                synced_next = 1'b1;
            end
            if (synced_next && playing)
            begin
                clock_level_next = ptcs_pkg::clock_high(tick, cfg.clock_ratio);
                reset_level_next = (tick >> 1) == '0;
            end
            else
            begin
                clock_level_next = 1'b0;
                reset_level_next = 1'b0;
            end
            prior_tick_next = {1'b0, tick};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            synced_reg        <= 1'b0;
            prior_playing_reg <= 1'b0;
            prior_tick_reg    <= ptcs_pkg::PRIOR_TICK_NONE;
            clock_level_reg   <= 1'b0;
            reset_level_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= hold_valid;
            if (hold_valid)
            begin
                synced_reg        <= synced_next;
                prior_playing_reg <= prior_playing_next;
                prior_tick_reg    <= prior_tick_next;
                clock_level_reg   <= clock_level_next;
                reset_level_reg   <= reset_level_next;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign clock_pulse      = clock_level_reg;
    assign bar_reset_pulse  = reset_level_reg;
    assign waiting_for_sync = !synced_reg;

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the phase to clock block with offset and swing
module tb_top;

    localparam int PHASE_W      = ptcs_pkg::PHASE_FRAC_BITS_DEF + 2;
    localparam int SUM_W        = PHASE_W + 2;
    localparam int TICK_LSB     = ptcs_pkg::PHASE_FRAC_BITS_DEF - 5;
    localparam int TICK_MSB     = TICK_LSB + ptcs_pkg::TICK_BITS - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               playing;
        logic               sync_on;
        logic               resync;
    } phase_sample_t;

    typedef struct packed {
        logic clock;
        logic bar_reset;
        logic waiting;
    } clock_levels_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_write = 1'b0;
    logic [ptcs_pkg::CFG_INDEX_W-1:0] cfg_index = ptcs_pkg::CFG_START_STOP;
    logic [ptcs_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [PHASE_W-1:0]               bar_phase = '0;
    logic                             partner_playing = 1'b0;
    logic                             partner_sync_on = 1'b0;
    logic                             resync_request = 1'b0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             clock_pulse;
    logic                             bar_reset_pulse;
    logic                             waiting_for_sync;

    phase_to_clock_with_swing u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .bar_phase        (bar_phase),
        .partner_playing  (partner_playing),
        .partner_sync_on  (partner_sync_on),
        .resync_request   (resync_request),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .clock_pulse      (clock_pulse),
        .bar_reset_pulse  (bar_reset_pulse),
        .waiting_for_sync (waiting_for_sync)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // register copies used for prediction
    logic                                 sse_q = 1'b0;
    logic [ptcs_pkg::OFFSET_W-1:0]        offset_q = '0;
    logic [ptcs_pkg::SWING_W-1:0]         swing_q = '0;
    logic [ptcs_pkg::RATIO_W-1:0]         ratio_q = ptcs_pkg::RATIO_RESET;

    // predicted block state
    logic                                 synced_q = 1'b0;
    logic                                 prior_playing_q = 1'b0;
    logic [ptcs_pkg::PRIOR_TICK_BITS-1:0] prior_tick_q = ptcs_pkg::PRIOR_TICK_NONE;
    logic                                 clock_level_q = 1'b0;
    logic                                 reset_level_q = 1'b0;

    phase_sample_t pending_samples[$];
    clock_levels_t expected_levels[$];

    int  queued_total = 0;
    int  accepted_requests = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  settings_used = 0;
    int  sync_locks = 0;
    int  sync_drops = 0;
    int  idle_pct = 20;
    bit  quiet = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  idle_cycles = 0;

    function automatic logic [ptcs_pkg::TICK_BITS-1:0] tick_of(
        input logic [SUM_W-1:0] units);
        return units[TICK_MSB:TICK_LSB];
    endfunction

    // advance the predicted state by one sample and return the held levels
    task automatic advance_levels(input phase_sample_t s, output clock_levels_t lv);
        logic                           playing;
        logic                           was_synced;
        logic [SUM_W-1:0]               sum;
        logic [ptcs_pkg::TICK_BITS-1:0] tick;
        logic [ptcs_pkg::TICK_BITS-1:0] period_mask;
        logic [ptcs_pkg::RATIO_W-1:0]   code;
        was_synced = synced_q;
        playing = 1'b1;
        if (s.resync)
            synced_q = 1'b0;
        if (s.sync_on)
        begin
            if (sse_q)
            begin
                playing = s.playing;
                if (playing && !prior_playing_q)
                    synced_q = 1'b0;
            end
            prior_playing_q = playing;
        end
        sum = {{(SUM_W-PHASE_W){1'b0}}, s.phase}
            + {{(SUM_W-ptcs_pkg::OFFSET_W){offset_q[ptcs_pkg::OFFSET_W-1]}}, offset_q};
        tick = tick_of(sum);
        // odd sixteenths are pushed late by the swing amount
        if (tick[ptcs_pkg::SWING_TICK_BIT])
            tick = tick_of(sum - {{(SUM_W-ptcs_pkg::SWING_W){1'b0}}, swing_q});
        if ({1'b0, tick} != prior_tick_q || !synced_q)
        begin
            if (tick == '0)
                synced_q = 1'b1;
            if (synced_q && playing)
            begin
                code = (ratio_q > ptcs_pkg::RATIO_MAX) ? ptcs_pkg::RATIO_MAX : ratio_q;
                period_mask = ptcs_pkg::TICK_ALL >> code;
                clock_level_q = (tick & period_mask) < 2;
                reset_level_q = tick < 2;
            end
            else
            begin
                clock_level_q = 1'b0;
                reset_level_q = 1'b0;
            end
            prior_tick_q = {1'b0, tick};
        end
        if (synced_q && !was_synced)
            sync_locks++;
        if (!synced_q && was_synced)
            sync_drops++;
        lv.clock = clock_level_q;
        lv.bar_reset = reset_level_q;
        lv.waiting = !synced_q;
    endtask

    always @(posedge clk)
    begin : request_driver
        logic          take;
        logic          next_valid;
        phase_sample_t s;
        clock_levels_t lv;
        if (rst_n)
        begin
            take = in_valid && !in_stall;
            next_valid = in_valid && !take;
            if (take)
            begin
                advance_levels({bar_phase, partner_playing, partner_sync_on, resync_request},
                               lv);
                expected_levels.push_back(lv);
                accepted_requests++;
            end
            if (!next_valid)
            begin
                if (quiet)
                    send_gap = 0;
                if (send_gap > 0)
                    send_gap--;
                else if (pending_samples.size() > 0)
                begin
                    s = pending_samples.pop_front();
                    bar_phase <= s.phase;
                    partner_playing <= s.playing;
                    partner_sync_on <= s.sync_on;
                    resync_request <= s.resync;
                    next_valid = 1'b1;
                    if (!quiet && $urandom_range(99) < idle_pct)
                        send_gap = $urandom_range(1, 13);
                end
            end
            in_valid <= next_valid;
        end
    end

    task automatic check_level(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t %s: expected %0b, actual %0b", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        clock_levels_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_levels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t result with nothing expected: expected none, actual %b%b%b",
                             $time, clock_pulse, bar_reset_pulse, waiting_for_sync);
                end
                else
                begin
                    want = expected_levels.pop_front();
                    check_level("clock_pulse", want.clock, clock_pulse);
                    check_level("bar_reset_pulse", want.bar_reset, bar_reset_pulse);
                    check_level("waiting_for_sync", want.waiting, waiting_for_sync);
                end
            end
            if (quiet)
            begin
                recv_gap = 0;
                out_stall <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(99) < idle_pct)
            begin
                recv_gap = $urandom_range(0, 12);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
                $display("phase_to_clock_with_swing: mismatch");
                $finish;
            end
        end
    end

    task automatic write_register(input ptcs_pkg::cfg_reg_t idx,
                                  input logic [ptcs_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            ptcs_pkg::CFG_START_STOP: sse_q = data[0];
            ptcs_pkg::CFG_OFFSET:     offset_q = data[ptcs_pkg::OFFSET_W-1:0];
            ptcs_pkg::CFG_SWING:      swing_q = data[ptcs_pkg::SWING_W-1:0];
            ptcs_pkg::CFG_RATIO:      ratio_q = data[ptcs_pkg::RATIO_W-1:0];
            default:                  ;
        endcase
    endtask

    task automatic apply_setting(input logic sse, input int offset, input int swing,
                                 input int ratio);
        write_register(ptcs_pkg::CFG_START_STOP, ptcs_pkg::CFG_DATA_W'(sse));
        write_register(ptcs_pkg::CFG_OFFSET, ptcs_pkg::CFG_DATA_W'(offset));
        write_register(ptcs_pkg::CFG_SWING, ptcs_pkg::CFG_DATA_W'(swing));
        write_register(ptcs_pkg::CFG_RATIO, ptcs_pkg::CFG_DATA_W'(ratio));
        settings_used++;
    endtask

    task automatic queue_sample(input int phase, input logic playing, input logic sync_on,
                                input logic resync);
        phase_sample_t s;
        s.phase = PHASE_W'(phase);
        s.playing = playing;
        s.sync_on = sync_on;
        s.resync = resync;
        pending_samples.push_back(s);
        queued_total++;
    endtask

    // mostly a forward-running bar position with occasional play, sync and resync changes
    task automatic queue_ramp(input int count, input int sync_on_pct);
        logic [PHASE_W-1:0] pos;
        logic               playing;
        logic               sync_on;
        int                 roll;
        pos = PHASE_W'(262144 - $urandom_range(0, 60000));
        playing = 1'b1;
        sync_on = $urandom_range(99) < sync_on_pct;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
                queue_sample($urandom_range(0, 262143), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            else
            begin
                if ($urandom_range(99) < 3)
                    sync_on = $urandom_range(99) < sync_on_pct;
                if ($urandom_range(99) < 5)
                    playing = !playing;
                if ($urandom_range(99) < 3)
                    pos = PHASE_W'($urandom_range(0, 262143));
                else if ($urandom_range(99) < 20)
                    pos = pos + PHASE_W'($urandom_range(0, 300));
                else
                    pos = pos + PHASE_W'($urandom_range(512, 4096));
                queue_sample(int'(pos), playing, sync_on, $urandom_range(99) < 2);
            end
        end
    endtask

    task automatic wait_for_drain();
        while (results_seen < queued_total)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: start/stop off, no offset or swing, 32 tick clock
        settings_used = 1;
        idle_pct = 20;
        queue_sample(262143, 1'b0, 1'b0, 1'b0);
        queue_sample(262143, 1'b0, 1'b0, 1'b0);
        queue_sample(0, 1'b0, 1'b0, 1'b0);
        queue_sample(0, 1'b0, 1'b0, 1'b0);
        queue_sample(2047, 1'b0, 1'b0, 1'b0);
        queue_sample(2048, 1'b0, 1'b0, 1'b0);
        queue_sample(4096, 1'b0, 1'b0, 1'b0);
        queue_sample(16384, 1'b0, 1'b0, 1'b0);
        queue_sample(65536, 1'b0, 1'b0, 1'b0);
        queue_sample(67584, 1'b0, 1'b0, 1'b0);
        queue_sample(131071, 1'b1, 1'b1, 1'b0);
        // resync drops sync, a later bar start locks again
        queue_sample(196608, 1'b0, 1'b1, 1'b1);
        queue_sample(200000, 1'b0, 1'b0, 1'b0);
        queue_sample(0, 1'b0, 1'b0, 1'b0);
        // resync on tick zero relocks in the same request
        queue_sample(1000, 1'b1, 1'b0, 1'b1);
        queue_sample(174762, 1'b1, 1'b1, 1'b1);
        queue_ramp(70, 50);
        wait_for_drain();

        apply_setting(1'b1, 10240, 6144, 4);
        idle_pct = 10;
        // play start edges with start/stop following the partner
        queue_sample(251904, 1'b0, 1'b1, 1'b0);
        queue_sample(254000, 1'b0, 1'b1, 1'b0);
        queue_sample(10000, 1'b1, 1'b1, 1'b0);
        queue_sample(20000, 1'b1, 1'b0, 1'b0);
        queue_sample(253952, 1'b1, 1'b1, 1'b0);
        queue_sample(260000, 1'b0, 1'b1, 1'b0);
        queue_sample(8192, 1'b1, 1'b0, 1'b0);
        queue_sample(8192, 1'b1, 1'b1, 1'b0);
        queue_ramp(85, 80);
        wait_for_drain();

        apply_setting(1'b1, -10240, 0, 0);
        idle_pct = 30;
        queue_ramp(95, 80);
        wait_for_drain();

        apply_setting(1'b0, 16383, 8191, 7);
        idle_pct = 0;
        queue_ramp(95, 50);
        wait_for_drain();

        apply_setting(1'b1, -16384, 3000, 1);
        idle_pct = 15;
        queue_ramp(95, 90);
        wait_for_drain();

        apply_setting(1'b1, $urandom_range(0, 20480) - 10240, $urandom_range(0, 8191), 3);
        idle_pct = 40;
        queue_ramp(95, 70);
        wait_for_drain();

        apply_setting(1'b0, $urandom_range(0, 32767) - 16384, $urandom_range(0, 6144),
                      $urandom_range(5, 6));
        idle_pct = 10;
        queue_ramp(95, 60);
        wait_for_drain();

        // closing stretch runs at full rate on both sides
        apply_setting(1'b1, 0, 2048, 2);
        quiet = 1'b1;
        queue_ramp(120, 80);
        wait_for_drain();

        if (expected_levels.size() != 0)
        begin
            mismatches++;
            $display("%0t results missing: expected %0d more, actual 0", $time,
                     expected_levels.size());
        end
        $display("checked %0d results from %0d requests over %0d register settings",
                 results_seen, accepted_requests, settings_used);
        $display("sync locked on bar start %0d times and was dropped %0d times",
                 sync_locks, sync_drops);
        if (mismatches == 0)
            $display("phase_to_clock_with_swing: match");
        else
            $display("phase_to_clock_with_swing: mismatch");
        $finish;
    end

endmodule
